>>> hw/rtl/fiws_pkg.sv
// Shared types and constants for the frame interval window statistics block.
`timescale 1ns / 1ps

package fiws_pkg;

	// Interval saturation width and limit
	localparam int unsigned INTERVAL_BITS = 16;
	localparam logic [31:0] INTERVAL_LIMIT = 32'((64'd1 << INTERVAL_BITS) - 64'd1);

	// Output field widths
	localparam int unsigned RATE_W     = 18;
	localparam int unsigned MEAN_IV_W  = 24;
	localparam int unsigned HELD_OUT_W = 9;
	localparam int unsigned WLEN_W     = 9;

	// Per-frame rate numerator: 1000 frames/s in Q.8
	localparam logic [RATE_W-1:0] RATE_NUM = 18'd256000;

	// Reset value of the window length register
	localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd60;

	// Result bus width, padded to whole bytes
	localparam int unsigned RES_BITS = RATE_W + MEAN_IV_W + 3 * INTERVAL_BITS + HELD_OUT_W;
	localparam int unsigned RES_W    = ((RES_BITS + 7) / 8) * 8;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> hw/rtl/fiws_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fiws_div #(
	parameter int unsigned DVD_W = 33,
	parameter int unsigned DVS_W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DVD_W-1:0]     dividend,
	input  logic [DVS_W-1:0]     divisor,
	output logic [DVD_W-1:0]     quotient,
	output fiws_pkg::div_stat_t  stat
);
	import fiws_pkg::*;

	localparam int unsigned CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   rem_sh;
	logic             fits;
	logic [DVS_W:0]   rem_sub;

	// Shift in the next dividend bit and trial-subtract
	always_comb begin
		rem_sh  = {rem_q, quo_q[DVD_W-1]};
		fits    = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> hw/rtl/fiws_ring.sv
// Interval and rate history rings: one write port, one registered read port.
`timescale 1ns / 1ps

module fiws_ring #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned IDX_W = 8
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [IDX_W-1:0]                    waddr,
	input  logic [fiws_pkg::INTERVAL_BITS-1:0]  wr_interval,
	input  logic [fiws_pkg::RATE_W-1:0]         wr_rate,
	input  logic [IDX_W-1:0]                    raddr,
	output logic [fiws_pkg::INTERVAL_BITS-1:0]  rd_interval,
	output logic [fiws_pkg::RATE_W-1:0]         rd_rate
);
	import fiws_pkg::*;

	logic [INTERVAL_BITS-1:0] interval_mem [DEPTH];
	logic [RATE_W-1:0]        rate_mem     [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			interval_mem[waddr] <= wr_interval;
			rate_mem[waddr]     <= wr_rate;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_interval <= interval_mem[raddr];
		rd_rate     <= rate_mem[raddr];
	end

endmodule

>>> hw/rtl/frame_interval_window_stats.sv
// Top level: frame interval window statistics with a shared serial divider.
// Frames are taken one at a time: a new frame is accepted only once the previous
//   result has been loaded into the output register. The divider and ring scan set
//   the pace, and a result held back by the receiver stalls the next one.
// The dividend width of the shared divider is 33 at MAX_WINDOW = 256.
// Reset (arst_n low): window length 60, history and previous stamp cleared.
`timescale 1ns / 1ps

module frame_interval_window_stats #(
	parameter int unsigned MAX_WINDOW = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Window length register
	input  logic                              cfg_wr_en,
	input  logic [fiws_pkg::WLEN_W-1:0]       cfg_wr_data,
	// Frame events
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [31:0]                       s_axis_tdata,  // timestamp_ms
	// Results
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// mean_rate_q8, mean_interval_q8, min_interval_ms, max_interval_ms,
	// last_interval_ms, frames_held, zero pad
	output logic [fiws_pkg::RES_W-1:0]        m_axis_tdata
);
	import fiws_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_WINDOW);
	localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int unsigned IT_W  = INTERVAL_BITS + CNT_W;
	localparam int unsigned RT_W  = RATE_W + CNT_W;
	localparam int unsigned DVD_A = (RT_W > IT_W + 8) ? RT_W : IT_W + 8;
	localparam int unsigned DVD_W = (DVD_A > RATE_W) ? DVD_A : RATE_W;
	localparam int unsigned DVS_W = (CNT_W > INTERVAL_BITS) ? CNT_W : INTERVAL_BITS;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RATE_GO,
		S_RATE_WAIT,
		S_SCAN,
		S_MR_GO,
		S_MR_WAIT,
		S_MI_GO,
		S_MI_WAIT,
		S_OUT
	} state_t;

	state_t                   state_q;
	logic [WLEN_W-1:0]        wlen_q;
	logic [IDX_W-1:0]         wslot_q;
	logic [CNT_W-1:0]         held_q;
	logic [31:0]              prev_stamp_q;
	logic [IT_W-1:0]          it_total_q;
	logic [RT_W-1:0]          rt_total_q;
	logic [INTERVAL_BITS-1:0] interval_q;
	logic [IDX_W-1:0]         slot_q;
	logic [CNT_W-1:0]         len_q;
	logic [CNT_W-1:0]         scan_q;
	logic                     cmp_s1;
	logic [INTERVAL_BITS-1:0] lo_q;
	logic [INTERVAL_BITS-1:0] hi_q;
	logic [RATE_W-1:0]        mean_rate_q;
	logic                     out_valid_q;
	logic [RES_W-1:0]         out_data_q;

	logic [CNT_W-1:0]         eff_len;
	logic [IDX_W-1:0]         slot_now;
	logic [31:0]              diff;
	logic [INTERVAL_BITS-1:0] interval_now;
	logic [CNT_W-1:0]         slot_inc;
	logic                     full;
	logic                     accept;
	logic                     ring_we;
	logic [IDX_W-1:0]         ring_raddr;
	logic [INTERVAL_BITS-1:0] rd_interval;
	logic [RATE_W-1:0]        rd_rate;
	logic                     div_start;
	logic [DVD_W-1:0]         div_dvd;
	logic [DVS_W-1:0]         div_dvs;
	logic [DVD_W-1:0]         div_quo;
	div_stat_t                div_stat;

	// Effective window length and current slot
	always_comb begin
		if (wlen_q == '0) begin
			eff_len = CNT_W'(1);
		end else if (32'(wlen_q) > 32'(MAX_WINDOW)) begin
			eff_len = CNT_W'(MAX_WINDOW);
		end else begin
			eff_len = CNT_W'(wlen_q);
		end
		slot_now = (CNT_W'(wslot_q) >= eff_len) ? '0 : wslot_q;
	end

	// Interval from the previous stamp, saturated, zero forced to one
	always_comb begin
		diff = s_axis_tdata - prev_stamp_q;
		if (diff > INTERVAL_LIMIT) begin
			interval_now = INTERVAL_LIMIT[INTERVAL_BITS-1:0];
		end else if (diff == '0) begin
			interval_now = INTERVAL_BITS'(1);
		end else begin
			interval_now = diff[INTERVAL_BITS-1:0];
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign full          = held_q >= len_q;
	assign slot_inc      = CNT_W'(slot_q) + CNT_W'(1);
	assign ring_we       = (state_q == S_RATE_WAIT) && div_stat.done;
	assign ring_raddr    = (state_q == S_SCAN) ? scan_q[IDX_W-1:0] : slot_q;

	// Divider operand selection
	always_comb begin
		div_start = 1'b0;
		div_dvd   = DVD_W'(RATE_NUM);
		div_dvs   = DVS_W'(interval_q);
		unique case (state_q)
			S_RATE_GO: begin
				div_start = 1'b1;
			end
			S_MR_GO: begin
				div_start = 1'b1;
				div_dvd   = DVD_W'(rt_total_q);
				div_dvs   = DVS_W'(held_q);
			end
			S_MI_GO: begin
				div_start = 1'b1;
				div_dvd   = DVD_W'({it_total_q, 8'd0});
				div_dvs   = DVS_W'(held_q);
			end
			default: begin
			end
		endcase
	end

	fiws_div #(
		.DVD_W (DVD_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	fiws_ring #(
		.DEPTH (MAX_WINDOW),
		.IDX_W (IDX_W)
	) u_ring (
		.clk         (clk),
		.we          (ring_we),
		.waddr       (slot_q),
		.wr_interval (interval_q),
		.wr_rate     (div_quo[RATE_W-1:0]),
		.raddr       (ring_raddr),
		.rd_interval (rd_interval),
		.rd_rate     (rd_rate)
	);

	// Sequencer, history state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			wlen_q       <= WLEN_RESET;
			wslot_q      <= '0;
			held_q       <= '0;
			prev_stamp_q <= '0;
			it_total_q   <= '0;
			rt_total_q   <= '0;
			out_valid_q  <= 1'b0;
			cmp_s1       <= 1'b0;
			scan_q       <= '0;
			interval_q   <= '0;
			slot_q       <= '0;
			len_q        <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			mean_rate_q  <= '0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				wlen_q     <= cfg_wr_data;
				wslot_q    <= '0;
				held_q     <= '0;
				it_total_q <= '0;
				rt_total_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						prev_stamp_q <= s_axis_tdata;
						interval_q   <= interval_now;
						slot_q       <= slot_now;
						len_q        <= eff_len;
						state_q      <= S_RATE_GO;
					end
				end
				S_RATE_GO: begin
					state_q <= S_RATE_WAIT;
				end
				S_RATE_WAIT: begin
					if (div_stat.done) begin
						// drop the oldest entry once the window is full
						if (full) begin
							held_q     <= len_q;
							it_total_q <= it_total_q - IT_W'(rd_interval) + IT_W'(interval_q);
							rt_total_q <= rt_total_q - RT_W'(rd_rate)
								+ RT_W'(div_quo[RATE_W-1:0]);
						end else begin
							held_q     <= held_q + CNT_W'(1);
							it_total_q <= it_total_q + IT_W'(interval_q);
							rt_total_q <= rt_total_q + RT_W'(div_quo[RATE_W-1:0]);
						end
						wslot_q <= (slot_inc >= len_q) ? '0 : slot_inc[IDX_W-1:0];
						scan_q  <= '0;
						cmp_s1  <= 1'b0;
						lo_q    <= interval_q;
						hi_q    <= interval_q;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// issue one read per cycle, compare in the next cycle
					if (scan_q < held_q) begin
						scan_q <= scan_q + CNT_W'(1);
						cmp_s1 <= 1'b1;
					end else begin
						cmp_s1 <= 1'b0;
					end
					if (cmp_s1) begin
						if (rd_interval < lo_q) begin
							lo_q <= rd_interval;
						end
						if (rd_interval > hi_q) begin
							hi_q <= rd_interval;
						end
					end
					if (scan_q == held_q && !cmp_s1) begin
						state_q <= S_MR_GO;
					end
				end
				S_MR_GO: begin
					state_q <= S_MR_WAIT;
				end
				S_MR_WAIT: begin
					if (div_stat.done) begin
						mean_rate_q <= div_quo[RATE_W-1:0];
						state_q     <= S_MI_GO;
					end
				end
				S_MI_GO: begin
					state_q <= S_MI_WAIT;
				end
				S_MI_WAIT: begin
					if (div_stat.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload, loaded only when the output register is free
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) begin
			out_data_q <= RES_W'({
				HELD_OUT_W'(held_q),
				interval_q,
				hi_q,
				lo_q,
				div_quo[MEAN_IV_W-1:0],
				mean_rate_q
			});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	// Window never holds more than its storage
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(MAX_WINDOW))
		else $error("held count above window storage");

	// Input is only taken while the divider is free
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !div_stat.busy)
		else $error("ready while divider busy");

	// Scan only starts once the new interval is counted
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (held_q != '0))
		else $error("scan with empty history");

	// Divider start only from an idle divider
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	// Window extremes bracket the last interval
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MR_GO) |-> (lo_q <= interval_q && hi_q >= interval_q))
		else $error("min/max do not bracket last interval");
`endif

endmodule

>>> test/frame_interval_window_stats_test.sv
// Self-checking testbench for the frame interval window statistics block.
`timescale 1ns / 1ps

module frame_interval_window_stats_test;
	import fiws_pkg::*;

	localparam int unsigned WINDOW_CAP   = 256;
	localparam int unsigned RUN_LIMIT    = 2_000_000;
	localparam int unsigned LONG_HOLD    = 1500;
	localparam int unsigned DRAIN_CYCLES = 400;
	localparam int unsigned PHASES       = 9;
	localparam bit ROW_CFG   = 1'b1;
	localparam bit ROW_FRAME = 1'b0;

	// Result fields, mean rate in the lowest bits
	typedef struct packed {
		logic [8:0]  held;
		logic [15:0] last_iv;
		logic [15:0] max_iv;
		logic [15:0] min_iv;
		logic [23:0] mean_iv;
		logic [17:0] mean_rate;
	} frame_stats_t;

	// One directed step: a window length write or a frame event
	typedef struct {
		bit           cfg_row;
		logic [31:0]  value;
		bit           typed;
		frame_stats_t want;
	} step_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en;
	logic [WLEN_W-1:0]   cfg_wr_data;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [31:0]         s_axis_tdata;   // timestamp_ms
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	// mean_rate_q8, mean_interval_q8, min_interval_ms, max_interval_ms,
	// last_interval_ms, frames_held, zero pad
	logic [RES_W-1:0]    m_axis_tdata;

	frame_interval_window_stats dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #4 clk = ~clk;

	// Predictor state: window length, interval/rate rings, totals
	logic [WLEN_W-1:0]  win_len;
	logic [15:0]        iv_ring [WINDOW_CAP];
	logic [17:0]        rate_ring [WINDOW_CAP];
	int unsigned        wr_slot;
	int unsigned        held;
	logic [31:0]        last_stamp;
	longint unsigned    iv_sum;
	longint unsigned    rate_sum;
	frame_stats_t       stats_due[$];

	logic [31:0]        stamp_cursor;
	bit                 idle_off = 1'b0;
	bit                 long_hold_req = 1'b0;
	int unsigned        fail_count = 0;
	int unsigned        cycle_count = 0;

	function automatic frame_stats_t frame_stats(input int unsigned rate,
			input int unsigned mean_iv, input int unsigned lo, input int unsigned hi,
			input int unsigned last_iv, input int unsigned n);
		frame_stats_t r;
		r.mean_rate = 18'(rate);
		r.mean_iv   = 24'(mean_iv);
		r.min_iv    = 16'(lo);
		r.max_iv    = 16'(hi);
		r.last_iv   = 16'(last_iv);
		r.held      = 9'(n);
		return r;
	endfunction

	function automatic void clear_window();
		wr_slot  = 0;
		held     = 0;
		iv_sum   = 0;
		rate_sum = 0;
	endfunction

	// Add one frame to the window and work out the statistics it reports
	function automatic frame_stats_t predict_frame(input logic [31:0] stamp);
		logic [31:0]  delta;
		logic [15:0]  iv;
		logic [17:0]  rt;
		logic [15:0]  lo;
		logic [15:0]  hi;
		int unsigned  num;
		int unsigned  len;
		int unsigned  slot;
		frame_stats_t r;
		delta = stamp - last_stamp;
		last_stamp = stamp;
		iv = (delta > INTERVAL_LIMIT) ? INTERVAL_LIMIT[15:0] : delta[15:0];
		if (iv == 16'd0)
			iv = 16'd1;
		num = 32'(RATE_NUM);
		rt = 18'(num / 32'(iv));
		// zero length acts as one, oversize as the ring depth
		len = (win_len == '0) ? 1 :
			((32'(win_len) > WINDOW_CAP) ? WINDOW_CAP : 32'(win_len));
		slot = (wr_slot >= len) ? 0 : wr_slot;
		if (held >= len) begin
			iv_sum   -= 64'(iv_ring[slot]);
			rate_sum -= 64'(rate_ring[slot]);
			held = len;
		end else begin
			held++;
		end
		iv_ring[slot]   = iv;
		rate_ring[slot] = rt;
		iv_sum   += 64'(iv);
		rate_sum += 64'(rt);
		wr_slot = (slot + 1 >= len) ? 0 : slot + 1;
		lo = iv;
		hi = iv;
		for (int unsigned i = 0; i < held; i++) begin
			if (iv_ring[i] < lo)
				lo = iv_ring[i];
			if (iv_ring[i] > hi)
				hi = iv_ring[i];
		end
		r.mean_rate = 18'(rate_sum / held);
		r.mean_iv   = 24'((iv_sum * 256) / held);
		r.min_iv    = lo;
		r.max_iv    = hi;
		r.last_iv   = iv;
		r.held      = 9'(held);
		return r;
	endfunction

	// Mostly short frame gaps, some zero, some around saturation, some wild jumps
	function automatic logic [31:0] next_stamp();
		int unsigned pick;
		logic [31:0] delta;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			delta = 32'd0;
		else if (pick < 55)
			delta = $urandom_range(1, 50);
		else if (pick < 78)
			delta = $urandom_range(51, 1000);
		else if (pick < 88)
			delta = $urandom_range(65530, 65541);
		else if (pick < 93)
			delta = $urandom_range(1001, 70000);
		else
			delta = $urandom;
		stamp_cursor = (pick >= 97) ? 32'($urandom) : stamp_cursor + delta;
		return stamp_cursor;
	endfunction

	function automatic void check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Offer one frame event; predict its statistics once the transaction is taken
	task automatic offer_frame(input logic [31:0] stamp, input bit typed,
			input frame_stats_t want);
		frame_stats_t calc;
		if (!idle_off && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_axis_tdata  <= stamp;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		calc = predict_frame(stamp);
		stats_due.insert(stats_due.size(), typed ? want : calc);
	endtask

	// Window length write once every pending result is out
	task automatic write_window(input logic [WLEN_W-1:0] len);
		s_axis_tvalid <= 1'b0;
		while (stats_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		win_len = len;
		clear_window();
	endtask

	// Result checker
	always @(posedge clk) begin : result_check
		frame_stats_t got;
		frame_stats_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = frame_stats_t'(m_axis_tdata[$bits(frame_stats_t)-1:0]);
			if (stats_due.size() == 0) begin
				$display("%0t: result expected none, got %h", $time, m_axis_tdata);
				fail_count++;
			end else begin
				want = stats_due[0];
				stats_due.delete(0);
				check_field("mean_rate_q8", want.mean_rate, got.mean_rate);
				check_field("mean_interval_q8", want.mean_iv, got.mean_iv);
				check_field("min_interval_ms", want.min_iv, got.min_iv);
				check_field("max_interval_ms", want.max_iv, got.max_iv);
				check_field("last_interval_ms", want.last_iv, got.last_iv);
				check_field("frames_held", want.held, got.held);
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side: random stall bursts, plus one long hold-off on request
	initial begin : result_sink
		int unsigned hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				m_axis_tready <= 1'b0;
			end else if (!idle_off && $urandom_range(0, 15) == 0) begin
				hold_left = $urandom_range(0, 11);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		step_row_t         plan [23];
		logic [WLEN_W-1:0] phase_len [PHASES];
		int unsigned       phase_items [PHASES];

		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		win_len       = WLEN_RESET;
		last_stamp    = '0;
		stamp_cursor  = '0;
		clear_window();

		plan = '{
			// first frame after reset: zero interval counts as 1 ms
			'{ROW_FRAME, 32'h0000_0000, 1'b1, frame_stats(256000, 256, 1, 1, 1, 1)},
			// huge interval saturates
			'{ROW_FRAME, 32'hFFFF_FFFF, 1'b1,
				frame_stats(128001, 8388608, 1, 65535, 65535, 2)},
			'{ROW_FRAME, 32'hFFFF_FFFF, 1'b0, '0},
			// stamp wraps past zero
			'{ROW_FRAME, 32'h0000_0004, 1'b0, '0},
			'{ROW_CFG,   32'd1,         1'b0, '0},
			'{ROW_FRAME, 32'd100,       1'b1, frame_stats(2666, 24576, 96, 96, 96, 1)},
			'{ROW_FRAME, 32'd1100,      1'b1,
				frame_stats(256, 256000, 1000, 1000, 1000, 1)},
			// zero window length acts as one
			'{ROW_CFG,   32'd0,         1'b0, '0},
			'{ROW_FRAME, 32'd1101,      1'b1, frame_stats(256000, 256, 1, 1, 1, 1)},
			// two-entry window drops its oldest interval
			'{ROW_CFG,   32'd2,         1'b0, '0},
			'{ROW_FRAME, 32'd1103,      1'b0, '0},
			'{ROW_FRAME, 32'd1106,      1'b0, '0},
			'{ROW_FRAME, 32'd1110,      1'b0, '0},
			// oversize window length is capped
			'{ROW_CFG,   32'd511,       1'b0, '0},
			'{ROW_FRAME, 32'd66645,     1'b0, '0},
			'{ROW_FRAME, 32'd132181,    1'b0, '0},
			'{ROW_FRAME, 32'd197715,    1'b0, '0},
			'{ROW_CFG,   32'd256,       1'b0, '0},
			'{ROW_FRAME, 32'd197965,    1'b0, '0},
			'{ROW_FRAME, 32'd197966,    1'b0, '0},
			'{ROW_CFG,   32'd60,        1'b0, '0},
			'{ROW_FRAME, 32'h8000_0000, 1'b0, '0},
			'{ROW_FRAME, 32'h7FFF_FFFF, 1'b0, '0}
		};

		phase_len   = '{9'd1, 9'd256, 9'd2, 9'd511, 9'd0, 9'($urandom_range(0, 511)),
			9'd3, 9'd60, 9'($urandom_range(1, 256))};
		phase_items = '{60, 300, 60, 60, 40, 120, 60, 150, 150};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed steps
		foreach (plan[i]) begin
			if (plan[i].cfg_row) begin
				write_window(plan[i].value[WLEN_W-1:0]);
			end else begin
				offer_frame(plan[i].value, plan[i].typed, plan[i].want);
				stamp_cursor = plan[i].value;
			end
		end

		// Random phases, one window length each; the last runs without idling
		for (int unsigned p = 0; p < PHASES; p++) begin
			idle_off = (p == PHASES - 1) || ($urandom_range(0, 4) == 0);
			write_window(phase_len[p]);
			if (p == 1)
				long_hold_req = 1'b1;
			for (int unsigned n = 0; n < phase_items[p]; n++)
				offer_frame(next_stamp(), 1'b0, '0);
		end

		s_axis_tvalid <= 1'b0;
		while (stats_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
